FILE: hdl/crt_pkg.sv
// Shared types and codes for the coordinate residency table.
package crt_pkg;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_UNLOAD = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    localparam int KEY_W   = 64;
    localparam int SLOT_W  = 8;
    localparam int TOTAL_W = 9;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_z;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic [TOTAL_W-1:0] entry_total;
    } result_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

FILE: hdl/coordinate_residency_table.sv
// Top level of the coordinate residency table: a chain of compare-and-shift slots.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  command | start, busy          | request (cmd, coord_x, coord_z)
//  result  | done (one-cycle)     | result (status, found, slot, entry_total)
//
// At the accepting edge of a command every slot compares the key and registers its
// match bit; in the following cycle the match bits are encoded, the table is updated
// (append or shift-down compaction across the slot chain) and the result is
// registered. busy is high for that apply cycle, so no new command is accepted while
// one is being applied. Reset clears the entry count and control state only; slot
// contents need no clearing since slots at or above the count are never matched.
// The receiver cannot stall: done is high for exactly one cycle per command.
module coordinate_residency_table #(
    parameter int CAPACITY = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  crt_pkg::request_t request,
    output logic              done,
    output crt_pkg::result_t  result
);
    import crt_pkg::*;

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int SXW = (IW > SLOT_W) ? IW : SLOT_W;
    localparam int TXW = (CW > TOTAL_W) ? CW : TOTAL_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [1:0]       cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             done_reg;
    logic             done_next;
    result_t          result_reg;
    result_t          result_next;

    logic             accept;
    logic [KEY_W-1:0] probe_key;
    logic [KEY_W-1:0] entries [CAPACITY];
    logic [CAPACITY-1:0] match_bits;
    logic [IW-1:0]    hit_slot;
    logic             hit;
    logic             full;
    cell_ctrl_t       ctrl;
    logic [IW-1:0]    slot_val;
    logic [1:0]       status_val;
    logic [SXW-1:0]   slot_ext;
    logic [TXW-1:0]   total_ext;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg == S_APPLY);
    assign probe_key = {request.coord_x, request.coord_z};

    // Slot chain: each slot hands its key down to its left neighbor on removal.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        crt_cell #(
            .IDX (i),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .compare_en (accept),
            .probe_key  (probe_key),
            .write_key  (key_reg),
            .count      (count_reg),
            .hit_slot   (hit_slot),
            .ctrl       (ctrl),
            .neighbor   ((i < CAPACITY - 1) ? entries[(i + 1) % CAPACITY] : entries[i]),
            .entry      (entries[i]),
            .match      (match_bits[i])
        );
    end

    // Keys are unique in the table, so at most one match bit is set:
    // OR the indexes of matching slots to encode it.
    always_comb
    begin
        hit_slot = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_bits[i])
            begin
                hit_slot = hit_slot | IW'(i);
            end
        end
    end

    assign hit  = |match_bits;
    assign full = (count_reg == CAP_C);

    // Decide the command's effect during the apply cycle.
    always_comb
    begin
        ctrl       = '0;
        count_next = count_reg;
        slot_val   = '0;
        status_val = ST_ABSENT;
        if (state_reg == S_APPLY)
        begin
            case (cmd_reg)
                CMD_LOAD:
                begin
                    if (hit)
                    begin
                        status_val = ST_PRESENT;
                        slot_val   = hit_slot;
                    end
                    else if (full)
                    begin
                        status_val = ST_FULL;
                    end
                    else
                    begin
                        status_val = ST_OK;
                        slot_val   = count_reg[IW-1:0];
                        ctrl.load  = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_UNLOAD:
                begin
                    if (hit)
                    begin
                        status_val = ST_OK;
                        slot_val   = hit_slot;
                        ctrl.shift = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    // Lookup; the unused code behaves the same way.
                    if (hit)
                    begin
                        status_val = ST_OK;
                        slot_val   = hit_slot;
                    end
                end
            endcase
        end
    end

    assign slot_ext  = SXW'(slot_val);
    assign total_ext = TXW'(count_next);

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next              = S_IDLE;
                done_next               = 1'b1;
                result_next.status      = status_val;
                result_next.found       = hit;
                result_next.slot        = slot_ext[SLOT_W-1:0];
                result_next.entry_total = total_ext[TOTAL_W-1:0];
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Hold the command beat for the apply cycle; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= request.cmd;
            key_reg <= probe_key;
        end
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hdl/crt_cell.sv
// One table slot: holds a key, compares it, and takes its right neighbor on removal.
module crt_cell #(
    parameter int IDX = 0,
    parameter int IW  = 8,
    parameter int CW  = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        compare_en,
    input  logic [crt_pkg::KEY_W-1:0]   probe_key,
    input  logic [crt_pkg::KEY_W-1:0]   write_key,
    input  logic [CW-1:0]               count,
    input  logic [IW-1:0]               hit_slot,
    input  crt_pkg::cell_ctrl_t         ctrl,
    input  logic [crt_pkg::KEY_W-1:0]   neighbor,
    output logic [crt_pkg::KEY_W-1:0]   entry,
    output logic                        match
);
    import crt_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);
    localparam logic [IW-1:0] IDX_S = IW'(IDX);

    logic [KEY_W-1:0] entry_reg;
    logic [KEY_W-1:0] entry_next;
    logic             match_reg;
    logic             match_next;

    always_comb
    begin
        match_next = match_reg;
        if (compare_en)
        begin
            match_next = (entry_reg == probe_key) && (IDX_C < count);
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift && (IDX_S >= hit_slot))
        begin
            entry_next = neighbor;
        end
        else if (ctrl.load && (IDX_C == count))
        begin
            entry_next = write_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

FILE: verif/tb_coordinate_residency_table.sv
// Self-checking testbench for the coordinate residency table: directed and random commands.
module tb_coordinate_residency_table;

    timeunit 1ns;
    timeprecision 1ps;

    import crt_pkg::*;

    localparam int          CAPACITY    = 256;
    localparam int          RAND_BEATS  = 1925;
    localparam int          PHASE_BEATS = 480;
    localparam int          DRAIN_WAIT  = 8;
    localparam int          CYCLE_LIMIT = 200_000;
    // Command code 3 is unused; the table must treat it as a lookup.
    localparam logic [1:0]  CMD_SPARE   = 2'd3;
    localparam logic [31:0] C_MIN       = 32'h8000_0000;
    localparam logic [31:0] C_MAX       = 32'h7FFF_FFFF;

    typedef struct {
        request_t req;
        bit       fixed;  // expected result typed into the row
        result_t  want;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;

    // Shadow copy of the table contents, kept in acceptance order.
    logic [63:0] resident_keys [CAPACITY];
    int unsigned resident_count;

    result_t     pending_results[$];
    dir_row_t    directed_rows[$];
    int unsigned error_count;
    int unsigned cycle_count;
    bit          gapless;

    coordinate_residency_table #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_error(string msg);
        error_count++;
        $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Apply one command to the shadow table and return the result it must produce.
    // Only entries below the count take part in matching.
    function automatic result_t table_outcome(request_t req);
        logic [63:0] key;
        int          hit;
        int unsigned slot;
        result_t     res;
        key  = {req.coord_x, req.coord_z};
        hit  = -1;
        slot = 0;
        for (int i = 0; i < resident_count; i++)
        begin
            if (resident_keys[i] == key)
            begin
                hit = i;
                break;
            end
        end
        res.found = (hit >= 0);
        case (req.cmd)
            CMD_LOAD:
            begin
                if (hit >= 0)
                begin
                    res.status = ST_PRESENT;
                    slot       = hit;
                end
                else if (resident_count >= CAPACITY)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    slot                      = resident_count;
                    resident_keys[slot]       = key;
                    resident_count++;
                    res.status                = ST_OK;
                end
            end
            CMD_UNLOAD:
            begin
                if (hit >= 0)
                begin
                    slot = hit;
                    // Close the gap: later entries slide down and keep their order.
                    for (int j = hit; j + 1 < resident_count; j++)
                        resident_keys[j] = resident_keys[j + 1];
                    resident_count--;
                    res.status = ST_OK;
                end
                else
                begin
                    res.status = ST_ABSENT;
                end
            end
            default:
            begin
                if (hit >= 0)
                begin
                    res.status = ST_OK;
                    slot       = hit;
                end
                else
                begin
                    res.status = ST_ABSENT;
                end
            end
        endcase
        res.slot        = slot[SLOT_W-1:0];
        res.entry_total = resident_count[TOTAL_W-1:0];
        return res;
    endfunction

    // Draw a key: mostly a resident one when asked, sometimes a resident one with a single
    // bit flipped in one coordinate, else a small value that collides often, else anything.
    function automatic logic [63:0] choose_key(int unsigned resident_pct);
        logic [63:0] key;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (resident_count != 0 && roll < resident_pct)
        begin
            key = resident_keys[$urandom_range(0, resident_count - 1)];
            if ($urandom_range(0, 5) == 0)
            begin
                if ($urandom_range(0, 1) == 1)
                    key[63:32] ^= 32'd1 << $urandom_range(0, 31);
                else
                    key[31:0] ^= 32'd1 << $urandom_range(0, 31);
            end
        end
        else if (roll % 4 == 0)
        begin
            key[63:32] = $urandom_range(0, 8) - 4;
            key[31:0]  = $urandom_range(0, 8) - 4;
        end
        else
        begin
            key = {$urandom, $urandom};
        end
        return key;
    endfunction

    task automatic add_row(logic [1:0] cmd, logic [31:0] x, logic [31:0] z, bit fixed,
                           logic [1:0] st, logic fnd, int slot, int total);
        dir_row_t row;
        row.req.cmd           = cmd;
        row.req.coord_x       = x;
        row.req.coord_z       = z;
        row.fixed             = fixed;
        row.want.status       = st;
        row.want.found        = fnd;
        row.want.slot         = SLOT_W'(slot);
        row.want.entry_total  = TOTAL_W'(total);
        directed_rows.push_back(row);
    endtask

    // Drive one command beat. Inputs change on the falling edge; acceptance is judged on
    // the rising edge from the pre-edge value of busy. The expectation is queued at the
    // accepting edge, so the store stays in command order.
    task automatic issue_command(request_t req, bit fixed, result_t want);
        int unsigned gap;
        result_t     predicted;
        gap = gapless ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        request <= req;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = table_outcome(req);
        pending_results.push_back(fixed ? want : predicted);
        @(negedge clk);
    endtask

    // Check every done strobe against the oldest pending expectation, field by field.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                report_error($sformatf("unexpected result beat %p", result));
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    report_error($sformatf("status %0d, want %0d", result.status, want.status));
                if (result.found !== want.found)
                    report_error($sformatf("found %0b, want %0b", result.found, want.found));
                if (result.slot !== want.slot)
                    report_error($sformatf("slot %0d, want %0d", result.slot, want.slot));
                if (result.entry_total !== want.entry_total)
                    report_error($sformatf("entry_total %0d, want %0d",
                                           result.entry_total, want.entry_total));
            end
        end
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        request_t    req;
        result_t     none;
        logic [63:0] key;
        int unsigned target;
        int unsigned roll;
        int unsigned load_pct;
        int unsigned unload_pct;

        error_count    = 0;
        cycle_count    = 0;
        resident_count = 0;
        gapless        = 1'b0;
        none           = '0;
        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;

        // Hold reset, then release it on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows: empty table, coordinate extremes, duplicate load, misses,
        // unused code, removal from the middle, the end and the front (order kept).
        add_row(CMD_LOOKUP, 32'd0, 32'd0, 1, ST_ABSENT, 0, 0, 0);
        add_row(CMD_UNLOAD, 32'd0, 32'd0, 1, ST_ABSENT, 0, 0, 0);
        add_row(CMD_LOAD,   C_MIN, C_MIN, 1, ST_OK,     0, 0, 1);
        add_row(CMD_LOAD,   C_MAX, C_MAX, 1, ST_OK,     0, 1, 2);
        add_row(CMD_LOAD,   C_MIN, C_MAX, 0, ST_OK,     0, 0, 0);
        add_row(CMD_LOAD,   C_MAX, C_MIN, 0, ST_OK,     0, 0, 0);
        add_row(CMD_LOAD,   32'hFFFF_FFFF, 32'd0, 0, ST_OK, 0, 0, 0);
        add_row(CMD_LOAD,   32'd0, 32'hFFFF_FFFF, 0, ST_OK, 0, 0, 0);
        add_row(CMD_LOAD,   C_MAX, C_MAX, 1, ST_PRESENT, 1, 1, 6);
        add_row(CMD_LOOKUP, C_MIN, C_MAX, 0, ST_OK,     0, 0, 0);
        add_row(CMD_LOOKUP, 32'd0, 32'd0, 1, ST_ABSENT, 0, 0, 6);
        add_row(CMD_SPARE,  32'hFFFF_FFFF, 32'd0, 0, ST_OK, 0, 0, 0);
        add_row(CMD_SPARE,  32'd1, 32'd1, 0, ST_OK,     0, 0, 0);
        add_row(CMD_UNLOAD, C_MAX, C_MAX, 0, ST_OK,     0, 0, 0);
        add_row(CMD_LOOKUP, C_MIN, C_MAX, 0, ST_OK,     0, 0, 0);
        add_row(CMD_LOOKUP, 32'd0, 32'hFFFF_FFFF, 0, ST_OK, 0, 0, 0);
        add_row(CMD_UNLOAD, C_MAX, C_MAX, 1, ST_ABSENT, 0, 0, 5);
        add_row(CMD_UNLOAD, 32'd0, 32'hFFFF_FFFF, 0, ST_OK, 0, 0, 0);
        add_row(CMD_UNLOAD, C_MIN, C_MIN, 0, ST_OK,     0, 0, 0);
        add_row(CMD_LOAD,   32'h5555_5555, 32'hAAAA_AAAA, 0, ST_OK, 0, 0, 0);
        add_row(CMD_LOAD,   32'hAAAA_AAAA, 32'h5555_5555, 0, ST_OK, 0, 0, 0);
        add_row(CMD_LOOKUP, 32'h5555_5555, 32'h5555_5555, 0, ST_ABSENT, 0, 0, 0);
        add_row(CMD_LOOKUP, 32'hAAAA_AAAA, 32'h5555_5555, 0, ST_OK, 0, 0, 0);

        foreach (directed_rows[i])
            issue_command(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);

        // Random part in phases, each steering the fill level toward a target: fill to
        // full (then hammer loads against a full table), drain to empty, a random level,
        // and full once more.
        for (int n = 0; n < RAND_BEATS; n++)
        begin
            if (n % PHASE_BEATS == 0)
            begin
                case (n / PHASE_BEATS)
                    0:       target = CAPACITY;
                    1:       target = 0;
                    2:       target = $urandom_range(1, CAPACITY - 1);
                    default: target = CAPACITY;
                endcase
            end
            // Alternate stretches of back-to-back beats with randomly spaced ones.
            if (n % 40 == 0)
                gapless = ($urandom_range(0, 3) == 0);

            if (resident_count < target)
            begin
                load_pct   = 85;
                unload_pct = 7;
            end
            else if (resident_count > target)
            begin
                load_pct   = 10;
                unload_pct = 75;
            end
            else
            begin
                load_pct   = 34;
                unload_pct = 33;
            end

            roll = $urandom_range(0, 99);
            if (roll < load_pct)
            begin
                req.cmd = CMD_LOAD;
                key     = choose_key(resident_count < target ? 10 : 40);
            end
            else if (roll < load_pct + unload_pct)
            begin
                req.cmd = CMD_UNLOAD;
                key     = choose_key(90);
            end
            else if (roll < 98)
            begin
                req.cmd = CMD_LOOKUP;
                key     = choose_key(70);
            end
            else
            begin
                req.cmd = CMD_SPARE;
                key     = choose_key(50);
            end
            req.coord_x = key[63:32];
            req.coord_z = key[31:0];
            issue_command(req, 1'b0, none);
        end
        start <= 1'b0;

        // Drain: wait out every pending result, then a further wait for stray results.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
